FILE: rtl/hsvdc_pkg.sv
`timescale 1ns / 1ps
// Package for the HSV to RGB converter with perceptual dim curve.
// Holds the dim-curve table and the arithmetic constants; depends on nothing.
package hsvdc_pkg;

    localparam int unsigned ChannelW = 8;
    localparam int unsigned HueW     = 16;

    // Hue offset: a multiple of 360 that lifts every 16-bit signed hue above zero.
    localparam logic [16:0] HueOffset = 17'd33120;

    // Reciprocal of 45 scaled by 2^20 (ceiling), exact for inputs below 74898.
    localparam logic [14:0] Recip45   = 15'd23302;
    localparam int unsigned Recip45Sh = 20;

    // Reciprocal of 15 scaled by 2^16 (ceiling), exact for inputs below 4681.
    localparam logic [12:0] Recip15   = 13'd4370;
    localparam int unsigned Recip15Sh = 16;

    localparam logic [5:0] SectorSpan = 6'd60;

    // Sector codes.
    localparam logic [2:0] SEC_RED_UP    = 3'd0;
    localparam logic [2:0] SEC_GREEN_DN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_UP  = 3'd2;
    localparam logic [2:0] SEC_BLUE_DN   = 3'd3;
    localparam logic [2:0] SEC_BLUE_UP   = 3'd4;
    localparam logic [2:0] SEC_RED_DN    = 3'd5;

    // Perceptual dim curve.
    localparam logic [7:0] LevelCurve [256] = '{
        8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
        8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
        8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
        8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
        8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
        8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
        8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
        8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
        8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
        8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
        8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
        8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
        8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
        8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
        8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
        8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
        8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
        8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
        8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
        8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
    };

endpackage

FILE: rtl/hsv_to_rgb_dim_curve_top.sv
`timescale 1ns / 1ps
// A word accepted with start passes through stages one to six and the output
// register, and then shows up on red/green/blue with done.
// Throughput: one word per cycle, every cycle; busy is always low because the
// seven-stage pipeline never holds, and the receiver cannot stall it.
// Reset (rst_n low, asynchronous) empties the pipeline and sets brightness to 255.
// File: HSV to RGB converter top level; depends on hsvdc_pkg.
module hsv_to_rgb_dim_curve_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel.
    input  logic                            start,
    output logic                            busy,
    input  logic signed [hsvdc_pkg::HueW-1:0] hue_degrees,
    input  logic [hsvdc_pkg::ChannelW-1:0]  saturation,
    // Brightness register write channel.
    input  logic                            brightness_valid,
    output logic                            brightness_ready,
    input  logic [hsvdc_pkg::ChannelW-1:0]  brightness,
    // Result channel.
    output logic                            done,
    output logic [hsvdc_pkg::ChannelW-1:0]  red,
    output logic [hsvdc_pkg::ChannelW-1:0]  green,
    output logic [hsvdc_pkg::ChannelW-1:0]  blue
);
    import hsvdc_pkg::*;

    // The pipeline never holds, so the command side is always open and the
    // brightness register takes a write in any cycle.
    assign busy             = 1'b0;
    assign brightness_ready = 1'b1;

    logic       accept;
    logic [7:0] bright_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= 8'd255;
        end
        else if (brightness_valid && brightness_ready)
        begin
            bright_reg <= brightness;
        end
    end

    // Valid bits travel alongside the data through stages one to six and the
    // output register.
    logic [6:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:1], accept};
        end
    end

    // Stage 1: both curve lookups, and the hue is lifted by a multiple of 360
    // so that the floored remainder becomes a plain unsigned remainder. The
    // sign-extended add wraps correctly because the true sum stays positive.
    logic [16:0] s1_hue_next;
    logic [7:0]  s1_val_next;
    logic [7:0]  s1_sat_next;
    logic [16:0] s1_hue_reg;
    logic [7:0]  s1_val_reg;
    logic [7:0]  s1_sat_reg;

    always_comb
    begin
        s1_hue_next = {hue_degrees[HueW-1], hue_degrees} + HueOffset;
        s1_val_next = LevelCurve[bright_reg];
        s1_sat_next = 8'd255 - LevelCurve[~saturation];
    end

    always_ff @(posedge clk)
    begin
        s1_hue_reg <= s1_hue_next;
        s1_val_reg <= s1_val_next;
        s1_sat_reg <= s1_sat_next;
    end

    // Stage 2: 360 is 8 times 45, so the low three bits pass straight through
    // and the upper bits are divided by 45 with a reciprocal multiply. The
    // floor value of the ramps is formed in parallel.
    logic [28:0] s2_qprod;
    logic [15:0] s2_lo_prod;
    logic [7:0]  s2_q_reg;
    logic [13:0] s2_y_reg;
    logic [2:0]  s2_low_reg;
    logic [7:0]  s2_val_reg;
    logic [7:0]  s2_lo_reg;
    logic        s2_grey_reg;

    always_comb
    begin
        s2_qprod   = 29'(s1_hue_reg[16:3]) * 29'(Recip45);
        s2_lo_prod = 16'(8'd255 - s1_sat_reg) * 16'(s1_val_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_q_reg    <= s2_qprod[Recip45Sh+7:Recip45Sh];
        s2_y_reg    <= s1_hue_reg[16:3];
        s2_low_reg  <= s1_hue_reg[2:0];
        s2_val_reg  <= s1_val_reg;
        s2_lo_reg   <= s2_lo_prod[15:8];
        s2_grey_reg <= (s1_sat_reg == 8'd0);
    end

    // Stage 3: remainder by 45, rebuilt into a hue in 0..359.
    logic [13:0] s3_rem;
    logic [8:0]  s3_hue_reg;
    logic [7:0]  s3_val_reg;
    logic [7:0]  s3_lo_reg;
    logic        s3_grey_reg;

    always_comb
    begin
        s3_rem = s2_y_reg - (14'(s2_q_reg) * 14'd45);
    end

    always_ff @(posedge clk)
    begin
        s3_hue_reg  <= {s3_rem[5:0], s2_low_reg};
        s3_val_reg  <= s2_val_reg;
        s3_lo_reg   <= s2_lo_reg;
        s3_grey_reg <= s2_grey_reg;
    end

    // Stage 4: sector by compare against the sector boundaries, then the
    // position inside the sector and the ramp height.
    logic [2:0] s4_sector;
    logic [8:0] s4_base;
    logic [2:0] s4_sector_reg;
    logic [5:0] s4_pos_reg;
    logic [7:0] s4_diff_reg;
    logic [7:0] s4_val_reg;
    logic [7:0] s4_lo_reg;
    logic       s4_grey_reg;

    always_comb
    begin
        if (s3_hue_reg >= 9'd300)
        begin
            s4_sector = SEC_RED_DN;
            s4_base   = 9'd300;
        end
        else if (s3_hue_reg >= 9'd240)
        begin
            s4_sector = SEC_BLUE_UP;
            s4_base   = 9'd240;
        end
        else if (s3_hue_reg >= 9'd180)
        begin
            s4_sector = SEC_BLUE_DN;
            s4_base   = 9'd180;
        end
        else if (s3_hue_reg >= 9'd120)
        begin
            s4_sector = SEC_GREEN_UP;
            s4_base   = 9'd120;
        end
        else if (s3_hue_reg >= 9'd60)
        begin
            s4_sector = SEC_GREEN_DN;
            s4_base   = 9'd60;
        end
        else
        begin
            s4_sector = SEC_RED_UP;
            s4_base   = 9'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sector_reg <= s4_sector;
        s4_pos_reg    <= 6'(s3_hue_reg - s4_base);
        s4_diff_reg   <= s3_val_reg - s3_lo_reg;
        s4_val_reg    <= s3_val_reg;
        s4_lo_reg     <= s3_lo_reg;
        s4_grey_reg   <= s3_grey_reg;
    end

    // Stage 5: rising and falling ramp products.
    logic [13:0] s5_up_reg;
    logic [13:0] s5_dn_reg;
    logic [2:0]  s5_sector_reg;
    logic [7:0]  s5_val_reg;
    logic [7:0]  s5_lo_reg;
    logic        s5_grey_reg;

    always_ff @(posedge clk)
    begin
        s5_up_reg     <= 14'(s4_diff_reg) * 14'(s4_pos_reg);
        s5_dn_reg     <= 14'(s4_diff_reg) * 14'(SectorSpan - s4_pos_reg);
        s5_sector_reg <= s4_sector_reg;
        s5_val_reg    <= s4_val_reg;
        s5_lo_reg     <= s4_lo_reg;
        s5_grey_reg   <= s4_grey_reg;
    end

    // Stage 6: divide both products by 60 (shift by two, then reciprocal of
    // 15) and add the floor.
    logic [24:0] s6_up_prod;
    logic [24:0] s6_dn_prod;
    logic [7:0]  s6_up_reg;
    logic [7:0]  s6_dn_reg;
    logic [2:0]  s6_sector_reg;
    logic [7:0]  s6_val_reg;
    logic [7:0]  s6_lo_reg;
    logic        s6_grey_reg;

    always_comb
    begin
        s6_up_prod = 25'(s5_up_reg[13:2]) * 25'(Recip15);
        s6_dn_prod = 25'(s5_dn_reg[13:2]) * 25'(Recip15);
    end

    always_ff @(posedge clk)
    begin
        s6_up_reg     <= s6_up_prod[Recip15Sh+7:Recip15Sh] + s5_lo_reg;
        s6_dn_reg     <= s6_dn_prod[Recip15Sh+7:Recip15Sh] + s5_lo_reg;
        s6_sector_reg <= s5_sector_reg;
        s6_val_reg    <= s5_val_reg;
        s6_lo_reg     <= s5_lo_reg;
        s6_grey_reg   <= s5_grey_reg;
    end

    // Output stage: the sector picks which channel holds the full value, which
    // the floor and which the ramp. Zero curved saturation gives grey.
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic       done_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_comb
    begin
        if (s6_grey_reg)
        begin
            red_next   = s6_val_reg;
            green_next = s6_val_reg;
            blue_next  = s6_val_reg;
        end
        else
        begin
            unique case (s6_sector_reg)
                SEC_RED_UP:
                begin
                    red_next   = s6_val_reg;
                    green_next = s6_up_reg;
                    blue_next  = s6_lo_reg;
                end
                SEC_GREEN_DN:
                begin
                    red_next   = s6_dn_reg;
                    green_next = s6_val_reg;
                    blue_next  = s6_lo_reg;
                end
                SEC_GREEN_UP:
                begin
                    red_next   = s6_lo_reg;
                    green_next = s6_val_reg;
                    blue_next  = s6_up_reg;
                end
                SEC_BLUE_DN:
                begin
                    red_next   = s6_lo_reg;
                    green_next = s6_dn_reg;
                    blue_next  = s6_val_reg;
                end
                SEC_BLUE_UP:
                begin
                    red_next   = s6_up_reg;
                    green_next = s6_lo_reg;
                    blue_next  = s6_val_reg;
                end
                default:
                begin
                    red_next   = s6_val_reg;
                    green_next = s6_lo_reg;
                    blue_next  = s6_dn_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // Every result must trace back to an accepted command.
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 7))
        else $error("result without a matching command");

    // The rebuilt hue must land below 360.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (s3_hue_reg < 9'd360))
        else $error("hue remainder out of range");

    // The position inside a sector must stay below the sector span.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (s4_pos_reg < SectorSpan))
        else $error("sector position out of range");

    // Both ramps must lie between the floor and the full value.
    a_ramp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> (s6_up_reg >= s6_lo_reg) && (s6_up_reg <= s6_val_reg) &&
                       (s6_dn_reg >= s6_lo_reg) && (s6_dn_reg <= s6_val_reg))
        else $error("ramp value outside floor and full value");

endmodule
